>>> rtl/core/gbs_pkg.sv
`timescale 1ns / 1ps

package gbs_pkg;

  // One detection box as it is held in the kept table.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
    logic [6:0]         label;
  } box_t;

  // Register byte addresses on the configuration port.
  localparam logic [2:0] ADDR_IOU_THRESHOLD  = 3'd0;
  localparam logic [2:0] ADDR_CLASS_AGNOSTIC = 3'd4;

  localparam logic [15:0] IOU_THRESHOLD_RESET = 16'd29491;

  // Cycles from a comparison issue to its registered suppress flag.
  localparam int unsigned CMP_LATENCY = 5;

endpackage

>>> rtl/core/gbs_cell.sv
`timescale 1ns / 1ps

// One entry of the kept table; entries rotate around the ring.
module gbs_cell (
  input  logic          clk_i,
  input  logic          shift_i,
  input  gbs_pkg::box_t nbr_i,
  input  logic          wr_i,
  input  gbs_pkg::box_t wr_box_i,
  output gbs_pkg::box_t box_o
);

  gbs_pkg::box_t box_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      box_q <= wr_box_i;
    end else if (shift_i) begin
      box_q <= nbr_i;
    end
  end

  assign box_o = box_q;

endmodule

>>> rtl/core/gbs_iou_cmp.sv
`timescale 1ns / 1ps

// Pipelined IoU test: flags inter * 65536 > threshold * union.
module gbs_iou_cmp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  gbs_pkg::box_t a_i,
  input  gbs_pkg::box_t b_i,
  input  logic [29:0]   area_a_i,
  input  logic [15:0]   thr_i,
  output logic          hit_o
);

  // Stage 1: overlap lengths on each axis.
  logic signed [16:0] ax0, ax1, bx0, bx1, ay0, ay1, by0, by1;
  logic signed [16:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [17:0] dx, dy;
  logic               apart_x, apart_y;

  always_comb begin
    ax0 = 17'(a_i.x);
    bx0 = 17'(b_i.x);
    ay0 = 17'(a_i.y);
    by0 = 17'(b_i.y);
    ax1 = ax0 + $signed({2'b00, a_i.w});
    bx1 = bx0 + $signed({2'b00, b_i.w});
    ay1 = ay0 + $signed({2'b00, a_i.h});
    by1 = by0 + $signed({2'b00, b_i.h});
    apart_x = (ax0 > bx1) || (ax1 < bx0);
    apart_y = (ay0 > by1) || (ay1 < by0);
    lo_x = (ax0 > bx0) ? ax0 : bx0;
    hi_x = (ax1 < bx1) ? ax1 : bx1;
    lo_y = (ay0 > by0) ? ay0 : by0;
    hi_y = (ay1 < by1) ? ay1 : by1;
    dx = 18'(hi_x) - 18'(lo_x);
    dy = 18'(hi_y) - 18'(lo_y);
  end

  logic        v1_q, v2_q, v3_q, v4_q, hit_q;
  logic        ov1_q;
  logic [14:0] ow1_q, oh1_q, bw1_q, bh1_q;
  logic [29:0] inter2_q, areab2_q;
  logic [29:0] inter3_q;
  logic [30:0] uni3_q;
  logic [29:0] inter4_q;
  logic [46:0] prod4_q;
  logic        nz4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      v1_q  <= valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      hit_q <= v4_q && nz4_q && ({inter4_q, 16'd0} > {1'b0, prod4_q});
    end
  end

  always_ff @(posedge clk_i) begin
    ov1_q    <= !apart_x && !apart_y && (dx != 18'd0) && (dy != 18'd0);
    ow1_q    <= dx[14:0];
    oh1_q    <= dy[14:0];
    bw1_q    <= b_i.w;
    bh1_q    <= b_i.h;
    inter2_q <= ov1_q ? (30'(ow1_q) * 30'(oh1_q)) : 30'd0;
    areab2_q <= 30'(bw1_q) * 30'(bh1_q);
    uni3_q   <= 31'(area_a_i) + 31'(areab2_q) - 31'(inter2_q);
    inter3_q <= inter2_q;
    prod4_q  <= 47'(thr_i) * 47'(uni3_q);
    nz4_q    <= (uni3_q != 31'd0);
    inter4_q <= inter3_q;
  end

  assign hit_o = hit_q;

endmodule

>>> rtl/core/greedy_box_suppression_unit.sv
`timescale 1ns / 1ps

// Greedy non-maximum suppression over a stream of score-sorted boxes. The kept
// boxes of the current frame sit in a ring of MAX_KEPT cells that rotates by one
// cell per cycle while a box is scanned, past a single pipelined IoU comparator,
// so every box takes one full turn of the ring and then drains the comparator
// and decides; the time per box is independent of how many boxes are kept. One
// box is worked on at a time; a new box is taken as soon as the previous one is
// decided, even while its result still waits on the output. A surviving box
// yields one output transfer carrying its position in the frame; if the table is
// already full the box is still reported, with the overflow flag set, but it is
// not stored. A box with the first-of-frame flag empties the table and restarts
// the position count. Configuration registers must be written only while the
// block is idle; the block itself does not enforce this.
module greedy_box_suppression_unit #(
  parameter int unsigned MAX_KEPT  = 64,
  parameter int unsigned MAX_BOXES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input box stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: corner_x[15:0], corner_y[31:16], box_width[46:32],
  // box_height[61:47], class_label[68:62], zeros[71:69].
  input  logic [71:0] s_axis_tdata_i,
  // tuser: first_of_frame[0].
  input  logic [0:0]  s_axis_tuser_i,
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: kept_position[9:0], zeros[15:10].
  output logic [15:0] m_axis_tdata_o,
  // tuser: table_overflow[0].
  output logic [0:0]  m_axis_tuser_o,
  // Configuration port.
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned CW = $clog2(MAX_KEPT + 1);
  localparam int unsigned PW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned DW = $clog2(gbs_pkg::CMP_LATENCY + 2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // Configuration registers.
  logic [15:0] iou_threshold_q;
  logic        class_agnostic_q;
  logic        cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iou_threshold_q  <= gbs_pkg::IOU_THRESHOLD_RESET;
      class_agnostic_q <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr_i[2] == gbs_pkg::ADDR_CLASS_AGNOSTIC[2]) begin
        class_agnostic_q <= pwdata_i[0];
      end else begin
        iou_threshold_q <= pwdata_i[15:0];
      end
    end
  end

  always_comb begin
    if (paddr_i[2] == gbs_pkg::ADDR_CLASS_AGNOSTIC[2]) begin
      prdata_o = {31'd0, class_agnostic_q};
    end else begin
      prdata_o = {16'd0, iou_threshold_q};
    end
  end

  // Incoming box unpacked.
  gbs_pkg::box_t in_box;
  assign in_box.x     = s_axis_tdata_i[15:0];
  assign in_box.y     = s_axis_tdata_i[31:16];
  assign in_box.w     = s_axis_tdata_i[46:32];
  assign in_box.h     = s_axis_tdata_i[61:47];
  assign in_box.label = s_axis_tdata_i[68:62];

  state_e        state_q;
  gbs_pkg::box_t query_q;
  logic [29:0]   area_a_q;
  logic [CW-1:0] total_q;
  logic [CW-1:0] rot_q;
  logic [DW-1:0] drain_q;
  logic [PW-1:0] pos_cnt_q;
  logic [PW-1:0] pos_q;
  logic          sup_q;
  logic          out_valid_q;
  logic [9:0]    out_pos_q;
  logic          out_ovf_q;

  logic          in_fire;
  logic          shift;
  logic          store;
  logic          hit;
  logic          issue;
  logic [PW-1:0] cur_pos;
  logic [31:0]   pos_ext;

  gbs_pkg::box_t ring [MAX_KEPT];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign cur_pos         = s_axis_tuser_i[0] ? '0 : pos_cnt_q;
  assign shift           = (state_q == ST_SCAN);
  assign issue           = shift && (rot_q < total_q) &&
                           (class_agnostic_q || (ring[0].label == query_q.label));
  assign store           = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready_i) &&
                           !sup_q && (total_q < CW'(MAX_KEPT));
  assign pos_ext         = 32'(pos_q);

  // Ring of kept entries; cell 0 feeds the comparator.
  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    gbs_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (shift),
      .nbr_i    (ring[(i + 1) % MAX_KEPT]),
      .wr_i     (store && (total_q == CW'(i))),
      .wr_box_i (query_q),
      .box_o    (ring[i])
    );
  end

  gbs_iou_cmp u_cmp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (issue),
    .a_i      (query_q),
    .b_i      (ring[0]),
    .area_a_i (area_a_q),
    .thr_i    (iou_threshold_q),
    .hit_o    (hit)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      query_q  <= in_box;
      area_a_q <= 30'(in_box.w) * 30'(in_box.h);
      pos_q    <= cur_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      rot_q       <= '0;
      drain_q     <= '0;
      pos_cnt_q   <= '0;
      sup_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_pos_q   <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      // The result register empties on its transfer unless a new result
      // replaces it in the same cycle.
      if (out_valid_q && m_axis_tready_i && !((state_q == ST_FINISH) && !sup_q)) begin
        out_valid_q <= 1'b0;
      end
      if (hit) begin
        sup_q <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            sup_q     <= 1'b0;
            rot_q     <= '0;
            pos_cnt_q <= (cur_pos == PW'(MAX_BOXES - 1)) ? '0 : cur_pos + 1'b1;
            if (s_axis_tuser_i[0]) begin
              total_q <= '0;
            end
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rot_q <= rot_q + 1'b1;
          if (rot_q == CW'(MAX_KEPT - 1)) begin
            drain_q <= DW'(gbs_pkg::CMP_LATENCY + 1);
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain_q <= drain_q - 1'b1;
          if (drain_q == DW'(1)) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || m_axis_tready_i) begin
            if (!sup_q) begin
              out_valid_q <= 1'b1;
              out_pos_q   <= pos_ext[9:0];
              out_ovf_q   <= (total_q >= CW'(MAX_KEPT));
            end
            if (store) begin
              total_q <= total_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_pos_q};
  assign m_axis_tuser_o  = out_ovf_q;

endmodule
